[hdl/mfb_pkg.sv]
// Shared types, constants and byte-select functions for the masked frame builder.
package mfb_pkg;

  localparam logic [7:0]  FIN_BIT        = 8'h80;
  localparam logic [7:0]  MASKED_FLAG    = 8'h80;
  localparam logic [6:0]  LEN_EXT16      = 7'd126;
  localparam logic [6:0]  LEN_EXT64      = 7'd127;
  localparam logic [30:0] LEN16_LIMIT    = 31'd65536;
  localparam logic [31:0] HEADER_SLACK   = 32'd14;
  localparam logic [30:0] CAPACITY_RESET = 31'd4096;

  // Header byte counts including the four mask bytes
  localparam logic [3:0] HDR_CNT_SHORT = 4'd6;
  localparam logic [3:0] HDR_CNT_MID   = 4'd8;
  localparam logic [3:0] HDR_CNT_LONG  = 4'd14;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_MID,
    LEN_LONG
  } len_mode_e;

  // One buffered run of result bytes caused by a single input transfer
  typedef struct packed {
    logic        too_large;
    logic        hdr;
    len_mode_e   mode;
    logic [3:0]  opcode;
    logic [30:0] len;
    logic [31:0] key;
    logic [7:0]  pbyte;
    logic [3:0]  count;
  } run_t;

  function automatic logic [7:0] mask_byte(logic [31:0] key, logic [1:0] phase);
    logic [7:0] b;
    unique case (phase)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [3:0] hdr_count(len_mode_e mode);
    logic [3:0] c;
    unique case (mode)
      LEN_SHORT: c = HDR_CNT_SHORT;
      LEN_MID:   c = HDR_CNT_MID;
      LEN_LONG:  c = HDR_CNT_LONG;
      default:   c = HDR_CNT_SHORT;
    endcase
    return c;
  endfunction

  // Header byte at position idx (0 = FIN/opcode byte)
  function automatic logic [7:0] hdr_byte(run_t r, logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == 4'd0) begin
      b = FIN_BIT | {4'h0, r.opcode};
    end else begin
      unique case (r.mode)
        LEN_SHORT: begin
          if (idx == 4'd1) b = MASKED_FLAG | {1'b0, r.len[6:0]};
          else             b = mask_byte(r.key, 2'(idx - 4'd2));
        end
        LEN_MID: begin
          unique case (idx)
            4'd1:    b = MASKED_FLAG | {1'b0, LEN_EXT16};
            4'd2:    b = r.len[15:8];
            4'd3:    b = r.len[7:0];
            default: b = mask_byte(r.key, 2'(idx - 4'd4));
          endcase
        end
        default: begin
          unique case (idx)
            4'd1:                      b = MASKED_FLAG | {1'b0, LEN_EXT64};
            4'd2, 4'd3, 4'd4, 4'd5:    b = 8'h00;
            4'd6:                      b = {1'b0, r.len[30:24]};
            4'd7:                      b = r.len[23:16];
            4'd8:                      b = r.len[15:8];
            4'd9:                      b = r.len[7:0];
            default:                   b = mask_byte(r.key, 2'(idx - 4'd10));
          endcase
        end
      endcase
    end
    return b;
  endfunction

  // Result byte at position idx of a run
  function automatic logic [7:0] run_byte(run_t r, logic [3:0] idx);
    logic [7:0] b;
    if (r.too_large)                                  b = 8'h00;
    else if (r.hdr && (idx < hdr_count(r.mode)))      b = hdr_byte(r, idx);
    else                                              b = r.pbyte;
    return b;
  endfunction

endpackage

[hdl/mfb_in_if.sv]
// Input item channel: valid/ready plus the unmasked item fields.
interface mfb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        carries_byte;
  logic        first_of_frame;
  logic [30:0] frame_length;
  logic [3:0]  frame_opcode;
  logic [31:0] mask_key;

  modport source (output valid, payload_byte, carries_byte, first_of_frame,
                  frame_length, frame_opcode, mask_key, input ready);
  modport sink   (input valid, payload_byte, carries_byte, first_of_frame,
                  frame_length, frame_opcode, mask_key, output ready);
endinterface

[hdl/mfb_out_if.sv]
// Result channel: valid/ready plus one encoded frame byte.
interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       too_large;

  modport source (output valid, out_byte, last_of_run, too_large, input ready);
  modport sink   (input valid, out_byte, last_of_run, too_large, output ready);
endinterface

[hdl/mfb_cfg_if.sv]
// Configuration write channel for the frame capacity register.
interface mfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] frame_capacity;

  modport source (output valid, frame_capacity, input ready);
  modport sink   (input valid, frame_capacity, output ready);
endinterface

[hdl/mfb_encoder.sv]
// Frame state, capacity check and run descriptor register for each input transfer.
module mfb_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfb_in_if.sink        in_i,
  mfb_cfg_if.sink       cfg_i,
  output logic          run_valid_o,
  output mfb_pkg::run_t run_o,
  input  logic          run_take_i
);
  import mfb_pkg::*;

  logic [30:0] cap_q;
  logic [31:0] mask_q, mask_d;
  logic [1:0]  phase_q, phase_d;
  logic        rej_q, rej_d;
  logic        run_valid_q;
  run_t        run_q, run_d;

  logic        in_xfer;
  logic        reject;
  logic        rej_eff;
  logic        pay;
  logic [31:0] key_eff;
  logic [1:0]  phase_eff;
  len_mode_e   mode;
  logic [3:0]  cnt;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !run_valid_q || run_take_i;
  assign in_xfer     = in_i.valid && in_i.ready;

  // Work out the run for the incoming item and the next frame state
  always_comb begin
    reject    = ({1'b0, in_i.frame_length} + HEADER_SLACK) > {1'b0, cap_q};
    rej_eff   = in_i.first_of_frame ? reject : rej_q;
    key_eff   = (in_i.first_of_frame && !reject) ? in_i.mask_key : mask_q;
    phase_eff = in_i.first_of_frame ? 2'd0 : phase_q;
    pay       = in_i.carries_byte && !rej_eff;

    if (in_i.frame_length < 31'(LEN_EXT16)) mode = LEN_SHORT;
    else if (in_i.frame_length < LEN16_LIMIT) mode = LEN_MID;
    else mode = LEN_LONG;

    if (in_i.first_of_frame && reject) cnt = 4'd1;
    else if (in_i.first_of_frame) cnt = hdr_count(mode) + {3'd0, pay};
    else cnt = {3'd0, pay};

    mask_d  = key_eff;
    rej_d   = rej_eff;
    phase_d = phase_eff + {1'b0, pay};

    run_d.too_large = in_i.first_of_frame && reject;
    run_d.hdr       = in_i.first_of_frame && !reject;
    run_d.mode      = mode;
    run_d.opcode    = in_i.frame_opcode;
    run_d.len       = in_i.frame_length;
    run_d.key       = key_eff;
    run_d.pbyte     = in_i.payload_byte ^ mask_byte(key_eff, phase_eff);
    run_d.count     = cnt;
  end

  // Hold capacity and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAPACITY_RESET;
      mask_q  <= '0;
      phase_q <= '0;
      rej_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) cap_q <= cfg_i.frame_capacity;
      if (in_xfer) begin
        mask_q  <= mask_d;
        phase_q <= phase_d;
        rej_q   <= rej_d;
      end
    end
  end

  // Load a run only when the item produces results; drop empty ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
    end else if (in_xfer) begin
      run_valid_q <= (cnt != 4'd0);
    end else if (run_take_i) begin
      run_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) run_q <= run_d;
  end

  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;
endmodule

[hdl/mfb_serializer.sv]
// Walks a run one byte per transfer into the output register.
module mfb_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          run_valid_i,
  input  mfb_pkg::run_t run_i,
  output logic          run_take_o,
  mfb_out_if.source     out_o
);
  import mfb_pkg::*;

  logic [3:0] idx_q;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       err_q;
  logic       load;
  logic       is_last;

  assign load       = run_valid_i && (!out_valid_q || out_o.ready);
  assign is_last    = (idx_q == (run_i.count - 4'd1));
  assign run_take_o = load && is_last;

  // Advance the byte index, restart on the final byte of a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Hold the result byte until transferred
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= run_byte(run_i, idx_q);
      last_q <= is_last;
      err_q  <= run_i.too_large;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.last_of_run = last_q;
  assign out_o.too_large   = err_q;
endmodule

[hdl/masked_frame_builder.sv]
// An input item passes the encoder's run register, then the serializer's byte register.
// The output carries one byte per cycle while the receiver is ready.
// A header item yields 6, 8 or 14 header bytes, one more when it carries a payload
// byte, and input stalls until the serializer has emitted them; a rejected one yields a single error byte.
// Reset: rst_ni clears frame state, mask and phase; capacity returns to 4096.
// Top level: encoder stage feeding the byte serializer.
module masked_frame_builder (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfb_in_if.sink    in_i,
  mfb_cfg_if.sink   cfg_i,
  mfb_out_if.source out_o
);
  import mfb_pkg::*;

  logic run_valid;
  logic run_take;
  run_t run;

  mfb_encoder u_encoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .run_valid_o (run_valid),
    .run_o       (run),
    .run_take_i  (run_take)
  );

  mfb_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_i       (run),
    .run_take_o  (run_take),
    .out_o       (out_o)
  );
endmodule

[sim/mfb_checker.sv]
// Frame byte predictor and scoreboard for the masked frame builder.
`timescale 1ns / 1ps
module mfb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mfb_in_if    in_mon,
  mfb_cfg_if   cfg_mon,
  mfb_out_if   out_mon,
  output int   error_count_o,
  output int   pending_o
);
  import mfb_pkg::*;

  // One expected byte on the result channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       too_large;
  } frame_byte_t;

  frame_byte_t frame_bytes_due[$];

  // Predictor copy of the block state
  logic [30:0] capacity_q;
  logic [31:0] key_q;
  logic [1:0]  phase_q;
  logic        rejected_q;
  int          mismatches;

  assign error_count_o = mismatches;

  function automatic frame_byte_t plain(logic [7:0] b);
    return '{data: b, last: 1'b0, too_large: 1'b0};
  endfunction

  // Mask key byte for a lane, lane 0 in the top byte
  function automatic logic [7:0] key_lane(logic [31:0] key, logic [1:0] lane);
    logic [31:0] shifted;
    shifted = key << (8 * lane);
    return shifted[31:24];
  endfunction

  // Work out the bytes that one accepted input transfer produces
  task automatic encode_item();
    frame_byte_t run[$];
    logic [30:0] len;
    int          k;
    len = in_mon.frame_length;
    if (in_mon.first_of_frame) begin
      phase_q = 2'd0;
      if ({1'b0, len} + HEADER_SLACK > {1'b0, capacity_q}) begin
        // Reject the frame: single error byte, drop the rest
        rejected_q = 1'b1;
        frame_bytes_due.push_back('{data: 8'h00, last: 1'b1, too_large: 1'b1});
        return;
      end
      rejected_q = 1'b0;
      key_q      = in_mon.mask_key;
      run.push_back(plain(FIN_BIT | {4'h0, in_mon.frame_opcode}));
      if (len < 31'(LEN_EXT16)) begin
        run.push_back(plain(MASKED_FLAG | {1'b0, len[6:0]}));
      end else if (len < LEN16_LIMIT) begin
        run.push_back(plain(MASKED_FLAG | {1'b0, LEN_EXT16}));
        run.push_back(plain(len[15:8]));
        run.push_back(plain(len[7:0]));
      end else begin
        run.push_back(plain(MASKED_FLAG | {1'b0, LEN_EXT64}));
        for (k = 0; k < 4; k++) run.push_back(plain(8'h00));
        run.push_back(plain({1'b0, len[30:24]}));
        run.push_back(plain(len[23:16]));
        run.push_back(plain(len[15:8]));
        run.push_back(plain(len[7:0]));
      end
      for (k = 0; k < 4; k++) run.push_back(plain(key_lane(key_q, 2'(k))));
    end
    // Mask the carried byte unless the frame was rejected
    if (in_mon.carries_byte && !rejected_q) begin
      run.push_back(plain(in_mon.payload_byte ^ key_lane(key_q, phase_q)));
      phase_q = phase_q + 2'd1;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) frame_bytes_due.push_back(run[k]);
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    $display("%0t: %s expected %02h actual %02h", $time, what, want, got);
  endtask

  // Compare one result transfer against the oldest expectation
  task automatic check_byte();
    frame_byte_t want;
    if (frame_bytes_due.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected: expected none, actual %02h last %b err %b",
               $time, out_mon.out_byte, out_mon.last_of_run, out_mon.too_large);
      return;
    end
    want = frame_bytes_due.pop_front();
    if (out_mon.out_byte !== want.data)
      report("out_byte", want.data, out_mon.out_byte);
    if (out_mon.last_of_run !== want.last)
      report("last_of_run", {7'd0, want.last}, {7'd0, out_mon.last_of_run});
    if (out_mon.too_large !== want.too_large)
      report("too_large", {7'd0, want.too_large}, {7'd0, out_mon.too_large});
  endtask

  // Watch all three channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = CAPACITY_RESET;
      key_q      = '0;
      phase_q    = '0;
      rejected_q = 1'b0;
      mismatches = 0;
      frame_bytes_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) capacity_q = cfg_mon.frame_capacity;
      if (in_mon.valid && in_mon.ready) encode_item();
      if (out_mon.valid && out_mon.ready) check_byte();
      pending_o <= frame_bytes_due.size();
    end
  end

endmodule

[sim/tb_masked_frame_builder.sv]
// Stimulus, receiver stalls and verdict for the masked frame builder.
`timescale 1ns / 1ps
module tb_masked_frame_builder;
  import mfb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_ITEMS   = 20;
  localparam int PHASES        = 6;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam logic [3:0] OP_RSVD   = 4'hF;

  localparam logic [30:0] CAP_MAX = 31'h7FFF_FFFF;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  typedef struct packed {
    logic [7:0]  payload;
    logic        carries;
    logic        first;
    logic [30:0] len;
    logic [3:0]  opcode;
    logic [31:0] key;
  } in_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        hold_req;
  logic        hold_ack;
  int          error_count;
  int          pending;
  int          cycle_count = 0;
  int          items_sent;
  int          burst_left;
  bit          no_gaps;
  logic [30:0] cap_now;

  mfb_in_if  in_if ();
  mfb_cfg_if cfg_if ();
  mfb_out_if out_if ();

  masked_frame_builder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  mfb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .cfg_mon       (cfg_if),
    .out_mon       (out_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall pattern, long hold-off on request
  initial begin
    rx_mode_e mode;
    int       window;
    mode          = RX_ALWAYS;
    window        = 0;
    out_if.ready  = 1'b0;
    hold_ack      = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req != hold_ack) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_ack = hold_req;
      end else begin
        if (window == 0) begin
          mode   = rx_mode_e'($urandom_range(0, 3));
          window = $urandom_range(16, 96);
        end
        window--;
        case (mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic in_item_t head_item(logic [30:0] len, logic [3:0] op, logic [31:0] key,
                                         logic carries, logic [7:0] pb);
    return '{payload: pb, carries: carries, first: 1'b1, len: len, opcode: op, key: key};
  endfunction

  // Non-first item; header fields are noise and must be ignored
  function automatic in_item_t body_item(logic carries, logic [7:0] pb);
    return '{payload: pb, carries: carries, first: 1'b0, len: 31'($urandom()),
             opcode: 4'($urandom_range(0, 15)), key: $urandom()};
  endfunction

  // Offer one item in bursts with random gaps, hold until transfer
  task automatic offer(input in_item_t it);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_if.valid          <= 1'b1;
    in_if.payload_byte   <= it.payload;
    in_if.carries_byte   <= it.carries;
    in_if.first_of_frame <= it.first;
    in_if.frame_length   <= it.len;
    in_if.frame_opcode   <= it.opcode;
    in_if.mask_key       <= it.key;
    do @(posedge clk_i); while (!in_if.ready);
    if (it.carries || it.first) items_sent++;
  endtask

  // Pause the sender until every expected byte has arrived
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_capacity(input logic [30:0] cap);
    drain();
    cfg_if.valid          <= 1'b1;
    cfg_if.frame_capacity <= cap;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cap_now = cap;
  endtask

  function automatic logic [30:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 31'($urandom_range(0, 125));
    if (r < 7) return 31'($urandom_range(126, 65535));
    if (r < 8) return 31'($urandom_range(65536, 32'h7FFF_FFFF));
    if (r < 9 || cap_now < 31'd14) return 31'($urandom());
    // Straddle the capacity boundary
    return cap_now - 31'd14 + 31'($urandom_range(0, 1));
  endfunction

  // Well-formed frame: header item then payload bytes, some idle items mixed in
  task automatic send_frame(input logic [30:0] len, input int nbytes);
    int k;
    offer(head_item(len, 4'($urandom_range(0, 15)), $urandom(), nbytes > 0,
                    8'($urandom_range(0, 255))));
    for (k = 1; k < nbytes; k++) begin
      if ($urandom_range(0, 9) == 0) offer(body_item(1'b0, 8'($urandom_range(0, 255))));
      offer(body_item(1'b1, 8'($urandom_range(0, 255))));
    end
  endtask

  initial begin
    int         ph;
    int         target;
    logic [30:0] cap;
    rst_ni                = 1'b0;
    hold_req              = 1'b0;
    no_gaps               = 1'b0;
    burst_left            = 0;
    items_sent            = 0;
    cap_now               = CAPACITY_RESET;
    in_if.valid           = 1'b0;
    in_if.payload_byte    = '0;
    in_if.carries_byte    = 1'b0;
    in_if.first_of_frame  = 1'b0;
    in_if.frame_length    = '0;
    in_if.frame_opcode    = OP_CONT;
    in_if.mask_key        = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.frame_capacity = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: pass-through before any frame, length forms, capacity edge
    offer(body_item(1'b1, 8'hA5));
    offer(body_item(1'b0, 8'h3C));
    offer(head_item(31'd0, OP_TEXT, 32'hFFFF_FFFF, 1'b1, 8'h00));
    offer(body_item(1'b1, 8'hFF));
    offer(body_item(1'b1, 8'h5A));
    offer(head_item(31'd125, OP_CLOSE, 32'h0000_0000, 1'b0, 8'hFF));
    offer(head_item(31'd126, OP_CONT, 32'h1234_5678, 1'b1, 8'hFF));
    offer(body_item(1'b1, 8'h00));
    offer(head_item(31'd4082, OP_RSVD, 32'h8000_0001, 1'b1, 8'h81));
    offer(head_item(31'd4083, OP_BINARY, 32'hDEAD_BEEF, 1'b1, 8'h77));
    offer(body_item(1'b1, 8'h11));
    offer(body_item(1'b0, 8'h22));
    offer(head_item(31'd5, OP_PING, 32'hC3A5_5A3C, 1'b0, 8'h00));
    offer(body_item(1'b1, 8'h7E));

    // Largest capacity: longest lengths and the overflow edge
    set_capacity(CAP_MAX);
    offer(head_item(31'd65535, OP_PONG, 32'hA5A5_A5A5, 1'b1, 8'h5A));
    offer(head_item(31'd65536, OP_TEXT, 32'h0102_0304, 1'b1, 8'hF0));
    offer(head_item(31'h7FFF_FFF1, OP_BINARY, 32'hFEDC_BA98, 1'b1, 8'h0F));
    offer(body_item(1'b1, 8'hC3));
    offer(head_item(31'h7FFF_FFF2, OP_TEXT, 32'h5555_AAAA, 1'b1, 8'h99));
    offer(body_item(1'b1, 8'h44));

    // Smallest capacities: reject everything, then fit an empty frame exactly
    set_capacity(31'd0);
    offer(head_item(31'd0, OP_TEXT, 32'h1111_2222, 1'b1, 8'h12));
    set_capacity(31'd14);
    offer(head_item(31'd0, OP_CLOSE, 32'h3333_4444, 1'b1, 8'h34));
    offer(body_item(1'b1, 8'h56));
    set_capacity(31'd13);
    offer(head_item(31'd0, OP_TEXT, 32'h5555_6666, 1'b0, 8'h00));

    // Random phases, each under its own capacity
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = CAPACITY_RESET;
        1:       cap = CAP_MAX;
        2:       cap = 31'($urandom_range(14, 300));
        3:       cap = 31'($urandom());
        4:       cap = 31'($urandom_range(65540, 70000));
        default: cap = 31'($urandom_range(0, 13));
      endcase
      set_capacity(cap);
      if (ph == 1) begin
        // Stall the receiver while the sender keeps pushing
        hold_req <= ~hold_req;
        no_gaps   = 1'b1;
        send_frame(31'd40, 24);
        no_gaps   = 1'b0;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          send_frame(pick_length(), $urandom_range(0, 10));
        end else begin
          offer('{payload: 8'($urandom_range(0, 255)), carries: 1'($urandom_range(0, 1)),
                  first: ($urandom_range(0, 3) == 0), len: pick_length(),
                  opcode: 4'($urandom_range(0, 15)), key: $urandom()});
        end
      end
    end

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
